FILE: hdl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, codes and alphabet helpers for the Base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

  // mode register codes
  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  // character lookup codes beyond the 64 alphabet values
  localparam logic [7:0] SEXTET_PAD = 8'd64;
  localparam logic [7:0] SEXTET_BAD = 8'd255;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // default depth of the group queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_item;
  } in_item_t;

  // output beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;
  } out_item_t;

  // one finished group, handed from front to back
  typedef struct packed {
    logic [3:0][7:0] vals;    // vals[0] goes out first
    logic [1:0]      cnt_m1;  // number of results minus one
    logic            last;
    logic [1:0]      status;
  } grp_t;

  // sextet value to alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h2F;
    if (v < 6'd26)      c = 8'h41 + {2'b00, v};
    else if (v < 6'd52) c = 8'h61 + {2'b00, v} - 8'd26;
    else if (v < 6'd62) c = 8'h30 + {2'b00, v} - 8'd52;
    else if (v == 6'd62) c = 8'h2B;
    return c;
  endfunction

  // character to sextet value, or the pad and bad codes
  function automatic logic [7:0] b64_sextet(input logic [7:0] c);
    logic [7:0] s;
    s = SEXTET_BAD;
    if (c >= 8'h41 && c <= 8'h5A)      s = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) s = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) s = c - 8'h30 + 8'd52;
    else if (c == 8'h2B)               s = 8'd62;
    else if (c == 8'h2F)               s = 8'd63;
    else if (c == PAD_CHAR)            s = SEXTET_PAD;
    return s;
  endfunction

endpackage

FILE: hdl/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front
// Accepts input beats, gathers groups and turns a finished group into a
// descriptor of up to four result bytes for the back end.
// ----------------------------------------------------------------------------
module b64_front import b64_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output grp_t     q_wdata
);

  logic        mode;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic        bad_char_seen, bad_char_seen_next;
  logic        pad_third, pad_third_next;

  logic        accept;
  logic        done;
  logic [7:0]  sx;
  logic        is_pad;
  logic        is_bad;
  logic        bad_new;
  logic [5:0]  s0;
  logic [2:0]  n;
  logic [23:0] enc_bits;
  logic [23:0] dec_bits;
  logic [1:0]  pads;
  logic [1:0]  dec_cnt_m1;
  grp_t        grp;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  // classify the beat and build the group descriptor
  always_comb begin
    sx       = b64_sextet(in_data.data_byte);
    is_pad   = (sx == SEXTET_PAD);
    is_bad   = (sx == SEXTET_BAD);
    bad_new  = bad_char_seen | is_bad;
    s0       = (is_pad || is_bad) ? 6'd0 : sx[5:0];
    n        = {1'b0, group_count} + 3'd1;
    dec_bits = {group_bits[17:0], s0};

    // encode: align a short group to the top and count the pads
    enc_bits = {group_bits[15:0], in_data.data_byte};
    pads     = 2'd0;
    case (n)
      3'd1: begin
        enc_bits = {in_data.data_byte, 16'h0000};
        pads     = 2'd2;
      end
      3'd2: begin
        enc_bits = {group_bits[7:0], in_data.data_byte, 8'h00};
        pads     = 2'd1;
      end
      default: begin
        pads = 2'd0;
      end
    endcase

    dec_cnt_m1 = 2'd2 - {1'b0, in_data.last_item & is_pad}
                      - {1'b0, in_data.last_item & pad_third};

    grp = '0;
    if (mode == MODE_ENC) begin
      done          = (n == 3'd3) || in_data.last_item;
      grp.vals[0]   = b64_char(enc_bits[23:18]);
      grp.vals[1]   = b64_char(enc_bits[17:12]);
      grp.vals[2]   = (pads == 2'd2) ? PAD_CHAR : b64_char(enc_bits[11:6]);
      grp.vals[3]   = (pads != 2'd0) ? PAD_CHAR : b64_char(enc_bits[5:0]);
      grp.cnt_m1    = 2'd3;
      grp.last      = in_data.last_item;
      grp.status    = ST_OK;
    end else begin
      done = (n == 3'd4) || in_data.last_item;
      if (n == 3'd4) begin
        grp.vals[0] = dec_bits[23:16];
        grp.vals[1] = dec_bits[15:8];
        grp.vals[2] = dec_bits[7:0];
        grp.cnt_m1  = dec_cnt_m1;
        grp.last    = in_data.last_item;
        grp.status  = bad_new ? ST_BAD_CHAR : ST_OK;
      end else begin
        // short final group: a single error beat
        grp.cnt_m1  = 2'd0;
        grp.last    = 1'b1;
        grp.status  = ST_BAD_LEN;
      end
    end

    q_push  = accept && done;
    q_wdata = grp;
  end

  // group state update
  always_comb begin
    group_bits_next    = group_bits;
    group_count_next   = group_count;
    bad_char_seen_next = bad_char_seen;
    pad_third_next     = pad_third;
    if (accept) begin
      if (done) begin
        group_bits_next  = '0;
        group_count_next = '0;
        pad_third_next   = 1'b0;
        if (mode == MODE_DEC && !in_data.last_item) bad_char_seen_next = bad_new;
        else                                          bad_char_seen_next = 1'b0;
      end else begin
        group_count_next = n[1:0];
        if (mode == MODE_ENC) begin
          group_bits_next = {group_bits[15:0], in_data.data_byte};
        end else begin
          group_bits_next    = dec_bits;
          bad_char_seen_next = bad_new;
          if (n == 3'd3) pad_third_next = is_pad;
        end
      end
    end
  end

  // mode register and group state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_ENC;
      group_bits    <= '0;
      group_count   <= '0;
      bad_char_seen <= 1'b0;
      pad_third     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode          <= cfg_data;
      group_bits    <= '0;
      group_count   <= '0;
      bad_char_seen <= 1'b0;
      pad_third     <= 1'b0;
    end else begin
      group_bits    <= group_bits_next;
      group_count   <= group_count_next;
      bad_char_seen <= bad_char_seen_next;
      pad_third     <= pad_third_next;
    end
  end

endmodule

FILE: hdl/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue
// Short first-in first-out queue of group descriptors between front and back.
// ----------------------------------------------------------------------------
module b64_queue import b64_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  grp_t wdata,
  input  logic pop,
  output grp_t rdata,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign rdata = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty))      fill <= fill + 1'b1;
      else if (!(push && !full) && (pop && !empty)) fill <= fill - 1'b1;
    end
  end

endmodule

FILE: hdl/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back
// Walks the head descriptor and sends its bytes one beat per cycle, while
// the output is not stalled, through the output register.
// ----------------------------------------------------------------------------
module b64_back import b64_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  grp_t      q_rdata,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = !out_valid || !out_stall;
  assign at_end = (idx == q_rdata.cnt_m1);
  assign q_pop  = load && !q_empty && at_end;

  // byte index within the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_data.out_byte <= q_rdata.vals[idx];
      out_data.out_last <= q_rdata.last && at_end;
      out_data.status   <= q_rdata.status;
    end
  end

endmodule

FILE: hdl/base64_codec_top.sv
// ----------------------------------------------------------------------------
// base64_codec_top
// Streaming Base64 encoder and decoder with the standard alphabet.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the group queue has room and
// sends one result per cycle while the output is not stalled. In encode
// mode every three bytes (or a short final group) become four characters,
// so the single-beat output port sets the pace. In decode mode every four
// characters become up to three bytes and input runs at one byte per
// cycle while the queue has room. A result passes through a queue slot
// and the output register. Writing mode clears any partly gathered group.
module base64_codec_top import b64_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  grp_t q_wdata;
  grp_t q_rdata;

  // gathering and classification
  b64_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // group queue
  b64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // result sequencing
  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: test/tb_base64_codec_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_codec_top
// Self-checking bench for the streaming Base64 codec. A queue of input beats
// feeds a clocked driver. A local model of the codec predicts every output
// beat as input is accepted, and a clocked monitor compares each output beat
// with the oldest prediction. Directed messages cover padding in both modes,
// and bad characters and bad lengths in decode. Random encode and decode
// phases follow, with random input gaps, random output stalls and mode writes between phases.
// ----------------------------------------------------------------------------
module tb_base64_codec_top;
  import b64_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  base64_codec_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  in_item_t  beats_to_send[$];
  out_item_t coded_due[$];
  int        mismatches = 0;
  int        cycle_count = 0;

  // model state
  logic        cur_mode = MODE_ENC;
  logic [23:0] grp_bits = '0;
  int          grp_fill = 0;
  logic        bad_seen = 1'b0;
  logic        third_pad = 1'b0;

  // idle draws, with quiet stretches of no idling
  int send_gap = 0;
  int send_quiet = 0;
  int recv_wait = 0;
  int recv_quiet = 0;

  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return ($urandom_range(0, 1) == 1) ? $urandom_range(0, 18) : 0;
  endfunction

  // 0..63 for an alphabet character, 64 for the pad, 255 otherwise
  function automatic int sextet_of(input logic [7:0] c);
    if (c == PAD_CHAR) return 64;
    for (int i = 0; i < 64; i++)
      if (b64_alpha[i] == c) return i;
    return 255;
  endfunction

  function automatic void clear_group();
    grp_bits = '0;
    grp_fill = 0;
    bad_seen = 1'b0;
    third_pad = 1'b0;
  endfunction

  // predict the output beats caused by one accepted input beat
  task automatic b64_step(input in_item_t it);
    logic [23:0] bits;
    logic [7:0]  ch;
    logic [1:0]  st;
    logic        is_pad;
    int          n, pads, cnt, s;
    n = grp_fill + 1;
    if (cur_mode == MODE_ENC) begin
      bits = {grp_bits[15:0], it.data_byte};
      if (n < 3 && !it.last_item) begin
        grp_bits = bits;
        grp_fill = n;
        return;
      end
      // short final group: zero fill, then pad
      bits = bits << (8 * (3 - n));
      pads = (n == 3) ? 0 : 3 - n;
      for (int k = 0; k < 4; k++) begin
        ch = b64_alpha[bits[23 - 6 * k -: 6]];
        if (k >= 4 - pads) ch = PAD_CHAR;
        coded_due.push_back('{ch, it.last_item && k == 3, ST_OK});
      end
      clear_group();
    end else begin
      s = sextet_of(it.data_byte);
      is_pad = (s == 64);
      if (s == 255) bad_seen = 1'b1;
      if (s > 63) s = 0;
      bits = {grp_bits[17:0], s[5:0]};
      if (n < 4) begin
        if (it.last_item) begin
          clear_group();
          coded_due.push_back('{8'h00, 1'b1, ST_BAD_LEN});
          return;
        end
        if (n == 3) third_pad = is_pad;
        grp_bits = bits;
        grp_fill = n;
        return;
      end
      st = bad_seen ? ST_BAD_CHAR : ST_OK;
      cnt = 3;
      if (it.last_item) begin
        if (is_pad) cnt--;
        if (third_pad) cnt--;
      end
      for (int k = 0; k < cnt; k++)
        coded_due.push_back('{bits[23 - 8 * k -: 8], it.last_item && k + 1 == cnt, st});
      grp_bits = '0;
      grp_fill = 0;
      third_pad = 1'b0;
      if (it.last_item) bad_seen = 1'b0;
    end
  endtask

  task automatic note_fail(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // input driver: one beat per queue entry, random gap after each
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) b64_step(in_data);
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (beats_to_send.size() != 0) begin
        in_data <= beats_to_send.pop_front();
        in_valid <= 1'b1;
        send_gap <= draw_wait(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor: compare each beat, then stall for a random while
  always @(posedge clk) begin : receive
    int        w;
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else begin
      w = recv_wait;
      if (out_valid && !out_stall) begin
        if (coded_due.size() == 0) begin
          note_fail($sformatf("unexpected beat byte %h last %b status %0d",
                              out_data.out_byte, out_data.out_last, out_data.status));
        end else begin
          want = coded_due.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last ||
              out_data.status !== want.status)
            note_fail($sformatf({"expected byte %h last %b status %0d, ",
                                 "got byte %h last %b status %0d"},
                                want.out_byte, want.out_last, want.status,
                                out_data.out_byte, out_data.out_last, out_data.status));
        end
        w = draw_wait(recv_quiet);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        recv_wait <= w - 1;
      end else begin
        out_stall <= 1'b0;
        recv_wait <= 0;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte = b;
    it.last_item = last;
    beats_to_send.push_back(it);
  endtask

  task automatic queue_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], close && i == s.len() - 1);
  endtask

  // random byte message for encoding
  task automatic queue_enc_msg(output int n);
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++)
      send_beat(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  // mostly well-formed text, with some bad characters, stray pads and cut lengths
  task automatic queue_dec_msg(output int n);
    logic [7:0] msg[$];
    int         groups, pads;
    groups = $urandom_range(1, 4);
    for (int i = 0; i < 4 * groups; i++)
      msg.push_back(b64_alpha[$urandom_range(0, 63)]);
    pads = $urandom_range(0, 2);
    for (int p = 0; p < pads; p++)
      msg[msg.size() - 1 - p] = PAD_CHAR;
    foreach (msg[i]) begin
      if ($urandom_range(0, 19) == 0) msg[i] = 8'($urandom_range(0, 255));
      else if ($urandom_range(0, 39) == 0) msg[i] = PAD_CHAR;
    end
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) void'(msg.pop_back());
    n = msg.size();
    foreach (msg[i])
      send_beat(msg[i], i == n - 1);
  endtask

  // everything sent and every predicted beat received
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_to_send.size() != 0 || in_valid || coded_due.size() != 0);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
    clear_group();
  endtask

  initial begin
    logic modes[6];
    int   sent, n;
    modes = '{MODE_ENC, MODE_DEC, MODE_DEC, MODE_ENC, MODE_ENC, MODE_DEC};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // encode: full group of extremes, one-byte and two-byte final groups
    write_mode(MODE_ENC);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h7F, 1'b1);
    send_beat(8'h01, 1'b0);
    send_beat(8'hFE, 1'b1);

    // decode: each alphabet range, one pad, two pads, sticky bad character
    // with a pad mid-group, short lengths, then a partial group cut by a mode write
    write_mode(MODE_DEC);
    queue_text("az+/", 1'b0);
    queue_text("AZ9=", 1'b1);
    queue_text("A*=B", 1'b0);
    queue_text("Zg==", 1'b1);
    queue_text("Zm9", 1'b1);
    queue_text("A", 1'b1);
    queue_text("Q", 1'b0);

    // random phases, some repeating the previous mode
    foreach (modes[p]) begin
      write_mode(modes[p]);
      sent = 0;
      while (sent < 68) begin
        if (modes[p] == MODE_ENC) queue_enc_msg(n);
        else queue_dec_msg(n);
        sent += n;
        // drain everything once in mid-phase
        if (p == 2 && sent >= 34 && sent - n < 34) wait_idle();
      end
      // sometimes leave a partial group for the next mode write to clear
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, modes[p] == MODE_ENC ? 2 : 3))
          send_beat(8'($urandom_range(0, 255)), 1'b0);
    end

    wait_idle();
    repeat (SETTLE_CYCLES + 2) @(posedge clk);
    if (mismatches == 0 && coded_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
